### rtl/copg_pkg.sv
// ----------------------------------------------------------------------------
// Circle octant point generator package
// Shared codes and the control word that rides with each queued step.
// ----------------------------------------------------------------------------
package copg_pkg;

  typedef enum logic {
    MODE_LOAD = 1'b0,
    MODE_STEP = 1'b1
  } mode_t;

  typedef struct packed {
    logic finished;
  } job_ctl_t;

  localparam int PIDX_W = 3;
  localparam logic [PIDX_W-1:0] LAST_POINT = 3'd7;

endpackage

### rtl/copg_fifo.sv
// ----------------------------------------------------------------------------
// Step queue
// Small register FIFO that decouples the walker from the point expander.
// ----------------------------------------------------------------------------
module copg_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] wdata,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         full,
  output logic         empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [W-1:0]    mem [DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [CNTW-1:0] count;

  assign full  = (count == CNTW'(DEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CNTW'(1);
        2'b01:   count <= count - CNTW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

### rtl/copg_front.sv
// ----------------------------------------------------------------------------
// Circle walker
// Accepts load and step beats, keeps the octant walk state and queues steps.
// ----------------------------------------------------------------------------
module copg_front #(
  parameter int COORD_MAX  = 2047,
  parameter int RADIUS_MAX = 1023,
  parameter int CW         = 11,
  parameter int RW         = 10,
  parameter int DW         = 14
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               mode,
  input  logic [CW-1:0]      center_x,
  input  logic [CW-1:0]      center_y,
  input  logic [RW-1:0]      radius,
  input  logic               q_full,
  output logic               q_push,
  output copg_pkg::job_ctl_t q_ctl,
  output logic [CW-1:0]      q_cx,
  output logic [CW-1:0]      q_cy,
  output logic [RW-1:0]      q_x,
  output logic [RW-1:0]      q_y
);

  logic [CW-1:0] center_col, center_col_next;
  logic [CW-1:0] center_row, center_row_next;
  logic [RW-1:0] col_offset, col_offset_next;
  logic [RW-1:0] row_offset, row_offset_next;
  logic [DW-1:0] decision, decision_next;
  logic          busy, busy_next;

  logic                 accept;
  logic [CW-1:0]        cx_sat;
  logic [CW-1:0]        cy_sat;
  logic [RW-1:0]        r_sat;
  logic                 dec_nonneg;
  logic signed [RW+1:0] nx_s;
  logic signed [RW+1:0] ny_s;
  logic signed [RW+1:0] diff_s;
  logic [DW-1:0]        nd;

  assign in_stall  = q_full;
  assign accept    = in_valid && !q_full;
  assign q_push    = accept && (mode == copg_pkg::MODE_STEP);
  assign q_ctl.finished = !busy;
  assign q_cx      = center_col;
  assign q_cy      = center_row;
  assign q_x       = col_offset;
  assign q_y       = row_offset;

  assign cx_sat = (32'(center_x) > COORD_MAX) ? CW'(COORD_MAX) : center_x;
  assign cy_sat = (32'(center_y) > COORD_MAX) ? CW'(COORD_MAX) : center_y;
  assign r_sat  = (32'(radius) > RADIUS_MAX) ? RW'(RADIUS_MAX) : radius;

  assign dec_nonneg = !decision[DW-1];
  assign nx_s   = $signed({2'b00, col_offset}) + (RW+2)'(1);
  assign ny_s   = $signed({2'b00, row_offset}) - $signed({{(RW+1){1'b0}}, dec_nonneg});
  assign diff_s = nx_s - $signed({2'b00, row_offset});
  assign nd = dec_nonneg ? (decision + (DW'(diff_s) << 2) + DW'(10))
                         : (decision + (DW'(nx_s) << 2) + DW'(6));

  always_comb begin
    center_col_next = center_col;
    center_row_next = center_row;
    col_offset_next = col_offset;
    row_offset_next = row_offset;
    decision_next   = decision;
    busy_next       = busy;
    if (accept) begin
      if (mode == copg_pkg::MODE_LOAD) begin
        center_col_next = cx_sat;
        center_row_next = cy_sat;
        col_offset_next = '0;
        row_offset_next = r_sat;
        decision_next   = DW'(3) - (DW'(r_sat) << 1);
        busy_next       = 1'b1;
      end else if (busy) begin
        if (ny_s < nx_s) begin
          busy_next = 1'b0;
        end else begin
          col_offset_next = nx_s[RW-1:0];
          row_offset_next = ny_s[RW-1:0];
          decision_next   = nd;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      center_col <= '0;
      center_row <= '0;
      col_offset <= '0;
      row_offset <= '0;
      decision   <= '0;
      busy       <= 1'b0;
    end else begin
      center_col <= center_col_next;
      center_row <= center_row_next;
      col_offset <= col_offset_next;
      row_offset <= row_offset_next;
      decision   <= decision_next;
      busy       <= busy_next;
    end
  end

endmodule

### rtl/copg_back.sv
// ----------------------------------------------------------------------------
// Point expander
// Turns the queued step at the head into its eight symmetric point beats, or one done beat.
// ----------------------------------------------------------------------------
module copg_back #(
  parameter int CW = 11,
  parameter int RW = 10,
  parameter int PW = 13
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_empty,
  input  copg_pkg::job_ctl_t   q_ctl,
  input  logic [CW-1:0]        q_cx,
  input  logic [CW-1:0]        q_cy,
  input  logic [RW-1:0]        q_x,
  input  logic [RW-1:0]        q_y,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [PW-1:0] point_x,
  output logic signed [PW-1:0] point_y,
  output logic                 point_valid,
  output logic                 circle_done,
  output logic                 last_of_step
);

  logic [copg_pkg::PIDX_W-1:0] idx;
  logic                        advance;
  logic                        last_beat;
  logic [RW-1:0]               off_a;
  logic [RW-1:0]               off_b;
  logic [PW-1:0]               base_x;
  logic [PW-1:0]               base_y;
  logic [PW-1:0]               px;
  logic [PW-1:0]               py;

  assign advance   = !q_empty && (!out_valid || !out_stall);
  assign last_beat = q_ctl.finished || (idx == copg_pkg::LAST_POINT);
  assign q_pop     = advance && last_beat;

  assign off_a  = idx[2] ? q_y : q_x;
  assign off_b  = idx[2] ? q_x : q_y;
  assign base_x = PW'(q_cx);
  assign base_y = PW'(q_cy);
  assign px = idx[0] ? (base_x - PW'(off_a)) : (base_x + PW'(off_a));
  assign py = idx[1] ? (base_y - PW'(off_b)) : (base_y + PW'(off_b));

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        idx <= last_beat ? '0 : idx + copg_pkg::PIDX_W'(1);
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (q_ctl.finished) begin
        point_x      <= '0;
        point_y      <= '0;
        point_valid  <= 1'b0;
        circle_done  <= 1'b1;
        last_of_step <= 1'b1;
      end else begin
        point_x      <= px;
        point_y      <= py;
        point_valid  <= 1'b1;
        circle_done  <= 1'b0;
        last_of_step <= (idx == copg_pkg::LAST_POINT);
      end
    end
  end

endmodule

### rtl/circle_octant_point_generator.sv
// ----------------------------------------------------------------------------
// Circle octant point generator
// Midpoint circle rasterizer with a walker, a step queue and a point expander.
// ----------------------------------------------------------------------------
// A load beat (mode 0) yields nothing; a step beat yields eight point beats,
// or one done beat once the walk has ended. The result port delivers one beat
// per cycle while out_stall is low, so a step holds the port for eight beats;
// a two-entry step queue lets the input side run ahead of the result side, and
// a done step occupies the result port for a single beat.
module circle_octant_point_generator #(
  parameter int COORD_MAX  = 2047,
  parameter int RADIUS_MAX = 1023,
  localparam int PW        = (($clog2(COORD_MAX + 1) > $clog2(RADIUS_MAX + 1)) ?
                              $clog2(COORD_MAX + 1) : $clog2(RADIUS_MAX + 1)) + 2
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 mode,
  input  logic [$clog2(COORD_MAX+1)-1:0]  center_x,
  input  logic [$clog2(COORD_MAX+1)-1:0]  center_y,
  input  logic [$clog2(RADIUS_MAX+1)-1:0] radius,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [PW-1:0] point_x,
  output logic signed [PW-1:0] point_y,
  output logic                 point_valid,
  output logic                 circle_done,
  output logic                 last_of_step
);

  localparam int CW = $clog2(COORD_MAX + 1);
  localparam int RW = $clog2(RADIUS_MAX + 1);
  localparam int DW = RW + 4;
  localparam int QW = $bits(copg_pkg::job_ctl_t) + 2 * CW + 2 * RW;

  copg_pkg::job_ctl_t push_ctl;
  copg_pkg::job_ctl_t head_ctl;
  logic [CW-1:0]      push_cx, push_cy, head_cx, head_cy;
  logic [RW-1:0]      push_x, push_y, head_x, head_y;
  logic               q_push, q_pop, q_full, q_empty;
  logic [QW-1:0]      q_wdata, q_rdata;

  copg_front #(
    .COORD_MAX (COORD_MAX),
    .RADIUS_MAX(RADIUS_MAX),
    .CW        (CW),
    .RW        (RW),
    .DW        (DW)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .mode    (mode),
    .center_x(center_x),
    .center_y(center_y),
    .radius  (radius),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_ctl   (push_ctl),
    .q_cx    (push_cx),
    .q_cy    (push_cy),
    .q_x     (push_x),
    .q_y     (push_y)
  );

  assign q_wdata = {push_ctl, push_cx, push_cy, push_x, push_y};

  copg_fifo #(
    .W    (QW),
    .DEPTH(2)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (q_push),
    .wdata(q_wdata),
    .pop  (q_pop),
    .rdata(q_rdata),
    .full (q_full),
    .empty(q_empty)
  );

  assign {head_ctl, head_cx, head_cy, head_x, head_y} = q_rdata;

  copg_back #(
    .CW(CW),
    .RW(RW),
    .PW(PW)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .q_ctl       (head_ctl),
    .q_cx        (head_cx),
    .q_cy        (head_cy),
    .q_x         (head_x),
    .q_y         (head_y),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .point_x     (point_x),
    .point_y     (point_y),
    .point_valid (point_valid),
    .circle_done (circle_done),
    .last_of_step(last_of_step)
  );

endmodule

### rtl/copg_checker.sv
// ----------------------------------------------------------------------------
// Circle octant point generator checker
// Port-level properties of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module copg_checker #(
  parameter int PW = 13
) (
  input logic                 clk,
  input logic                 rst,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic signed [PW-1:0] point_x,
  input logic signed [PW-1:0] point_y,
  input logic                 point_valid,
  input logic                 circle_done,
  input logic                 last_of_step
);

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(point_x) && $stable(point_y)
      && $stable(last_of_step))
    else $error("stalled result beat changed");

  a_done_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && circle_done |-> last_of_step && !point_valid
      && (point_x == '0) && (point_y == '0))
    else $error("done beat is malformed");

  a_empty_is_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && !point_valid |-> circle_done)
    else $error("beat without a point is not marked done");

  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result beat right after reset");

endmodule

bind circle_octant_point_generator copg_checker #(.PW(PW)) u_copg_checker (.*);

### dv/tb_circle_octant_point_generator.sv
// ----------------------------------------------------------------------------
// Circle octant point generator testbench
// Feeds load and step beats through a clocked driver and compares every result
// beat with a cycle-free model of the midpoint circle walk. A directed opening
// covers the corner cases. Random circles follow under three idling patterns,
// and one long hold-off on the result side backs the block up into its input.
// ----------------------------------------------------------------------------
module tb_circle_octant_point_generator;

  typedef struct {
    copg_pkg::mode_t mode;
    logic [10:0]     cx;
    logic [10:0]     cy;
    logic [9:0]      r;
  } circle_cmd_t;

  typedef struct {
    logic signed [12:0] px;
    logic signed [12:0] py;
    logic               pv;
    logic               done;
    logic               last;
  } pixel_beat_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               mode = 1'b0;
  logic [10:0]        center_x = '0;
  logic [10:0]        center_y = '0;
  logic [9:0]         radius = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [12:0] point_x;
  logic signed [12:0] point_y;
  logic               point_valid;
  logic               circle_done;
  logic               last_of_step;

  circle_cmd_t cmd_feed[$];
  pixel_beat_t pending_pixels[$];
  circle_cmd_t accepted_cmd;
  pixel_beat_t got_beat;

  logic [10:0]        walk_cx = '0;
  logic [10:0]        walk_cy = '0;
  logic [9:0]         walk_x = '0;
  logic [9:0]         walk_y = '0;
  logic signed [13:0] walk_d = '0;
  logic               walk_active = 1'b0;

  int send_idle_pct = 9;
  int recv_idle_pct = 72;
  int hold_requests = 0;
  int holds_started = 0;
  int hold_left = 0;
  int items_queued = 0;
  int mismatches = 0;
  int circles_loaded = 0;
  int steps_taken = 0;
  int pixels_checked = 0;
  int done_beats_checked = 0;
  int drain_guard;

  circle_octant_point_generator u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .mode         (mode),
    .center_x     (center_x),
    .center_y     (center_y),
    .radius       (radius),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .point_x      (point_x),
    .point_y      (point_y),
    .point_valid  (point_valid),
    .circle_done  (circle_done),
    .last_of_step (last_of_step)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic void note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch: %s", msg);
    end
  endfunction

  task automatic walk_circle(input circle_cmd_t c);
    int x;
    int y;
    int a;
    int b;
    int nx;
    int ny;
    int nd;
    int k;
    pixel_beat_t pb;
    if (c.mode == copg_pkg::MODE_LOAD) begin
      walk_cx = c.cx;
      walk_cy = c.cy;
      walk_x = '0;
      walk_y = c.r;
      walk_d = 14'(3 - 2 * int'(c.r));
      walk_active = 1'b1;
      circles_loaded++;
    end else if (!walk_active) begin
      pb = '{13'sd0, 13'sd0, 1'b0, 1'b1, 1'b1};
      pending_pixels.push_back(pb);
      steps_taken++;
    end else begin
      x = int'(walk_x);
      y = int'(walk_y);
      for (k = 0; k < 8; k++) begin
        a = (k < 4) ? x : y;
        b = (k < 4) ? y : x;
        pb.px = 13'(int'(walk_cx) + (((k & 1) != 0) ? -a : a));
        pb.py = 13'(int'(walk_cy) + (((k & 2) != 0) ? -b : b));
        pb.pv = 1'b1;
        pb.done = 1'b0;
        pb.last = (k == 7);
        pending_pixels.push_back(pb);
      end
      nx = x + 1;
      ny = y;
      if (walk_d < 0) begin
        nd = int'(walk_d) + 4 * nx + 6;
      end else begin
        nd = int'(walk_d) + 4 * (nx - y) + 10;
        ny = y - 1;
      end
      if (ny < nx) begin
        walk_active = 1'b0;
      end else begin
        walk_x = 10'(nx);
        walk_y = 10'(ny);
        walk_d = 14'(nd);
      end
      steps_taken++;
    end
  endtask

  task automatic push_cmd(input copg_pkg::mode_t m, input int cx, input int cy,
                          input int r);
    circle_cmd_t c;
    c.mode = m;
    c.cx = 11'(cx);
    c.cy = 11'(cy);
    c.r = 10'(r);
    cmd_feed.push_back(c);
    items_queued++;
  endtask

  task automatic push_circle(input int cx, input int cy, input int r, input int nsteps);
    int i;
    push_cmd(copg_pkg::MODE_LOAD, cx, cy, r);
    for (i = 0; i < nsteps; i++) begin
      push_cmd(copg_pkg::MODE_STEP, $urandom_range(2047), $urandom_range(2047),
               $urandom_range(1023));
    end
  endtask

  task automatic queue_random_circles(input int n);
    int target;
    int sel;
    int r;
    target = items_queued + n;
    while (items_queued < target) begin
      sel = $urandom_range(9);
      if (sel == 0) begin
        push_cmd(copg_pkg::MODE_STEP, $urandom_range(2047), $urandom_range(2047),
                 $urandom_range(1023));
      end else if (sel == 1) begin
        push_cmd(copg_pkg::MODE_LOAD, $urandom_range(2047), $urandom_range(2047),
                 $urandom_range(1023));
      end else if ($urandom_range(7) == 0) begin
        r = $urandom_range(1023);
        push_circle($urandom_range(2047), $urandom_range(2047), r, $urandom_range(4, 1));
      end else begin
        r = $urandom_range(15);
        push_circle($urandom_range(2047), $urandom_range(2047), r,
                    $urandom_range(r * 7 / 10 + 3, 1));
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        accepted_cmd = cmd_feed.pop_front();
        walk_circle(accepted_cmd);
      end
      if (cmd_feed.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        mode <= cmd_feed[0].mode;
        center_x <= cmd_feed[0].cx;
        center_y <= cmd_feed[0].cy;
        radius <= cmd_feed[0].r;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (holds_started != hold_requests) begin
        holds_started++;
        hold_left = 80;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_pixels.size() == 0) begin
        note_mismatch($sformatf("unexpected beat x=%0d y=%0d valid=%0b done=%0b last=%0b",
                                point_x, point_y, point_valid, circle_done, last_of_step));
      end else begin
        got_beat = pending_pixels.pop_front();
        if (got_beat.pv) begin
          pixels_checked++;
        end else begin
          done_beats_checked++;
        end
        if (point_x !== got_beat.px || point_y !== got_beat.py ||
            point_valid !== got_beat.pv || circle_done !== got_beat.done ||
            last_of_step !== got_beat.last) begin
          note_mismatch($sformatf(
            {"expected x=%0d y=%0d valid=%0b done=%0b last=%0b, ",
             "got x=%0d y=%0d valid=%0b done=%0b last=%0b"},
            got_beat.px, got_beat.py, got_beat.pv, got_beat.done, got_beat.last,
            point_x, point_y, point_valid, circle_done, last_of_step));
        end
      end
    end
  end

  initial begin
    #4000000;
    $display("timeout with %0d beats still expected", pending_pixels.size());
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    push_cmd(copg_pkg::MODE_STEP, 2047, 2047, 1023);
    push_circle(0, 0, 0, 2);
    push_circle(2047, 2047, 1023, 3);
    push_circle(0, 0, 1023, 2);
    push_circle(1024, 5, 1, 2);
    push_circle(5, 2047, 2, 3);
    push_circle(2047, 0, 3, 1);
    push_circle(1365, 682, 682, 1);
    push_circle(682, 1365, 341, 1);
    push_cmd(copg_pkg::MODE_STEP, 0, 0, 0);
    queue_random_circles(45);
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    while (cmd_feed.size() != 0) @(negedge clk);

    @(negedge clk);
    send_idle_pct = 72;
    recv_idle_pct = 9;
    queue_random_circles(50);
    while (cmd_feed.size() != 0) @(negedge clk);

    @(negedge clk);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random_circles(50);
    hold_requests++;
    while (cmd_feed.size() != 0) @(negedge clk);

    drain_guard = 0;
    while (pending_pixels.size() != 0 && drain_guard < 100000) begin
      @(negedge clk);
      drain_guard++;
    end
    repeat (40) @(negedge clk);
    if (pending_pixels.size() != 0) begin
      note_mismatch($sformatf("%0d expected beats never arrived", pending_pixels.size()));
    end

    $display("run covered %0d circle loads and %0d steps, %0d long result hold-off(s)",
             circles_loaded, steps_taken, hold_requests);
    $display("checked %0d pixel beats and %0d done beats, %0d mismatches",
             pixels_checked, done_beats_checked, mismatches);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### sim.f
rtl/copg_pkg.sv
rtl/copg_fifo.sv
rtl/copg_front.sv
rtl/copg_back.sv
rtl/circle_octant_point_generator.sv
rtl/copg_checker.sv
dv/tb_circle_octant_point_generator.sv
